@@ hdl/wsp_pkg.sv @@
// wsp_pkg: shared types and constants for the WAV stream header parser.
// Word structs, config struct, walker phases, status codes and tag helpers.
// No dependencies.
`timescale 1ns / 1ps

package wsp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [3:0]  status;
        logic [1:0]  sample_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] data_size;
    } t_out_word;

    typedef struct packed {
        logic [15:0] pcm_tag;
        logic [15:0] float_tag;
    } t_cfg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PCM_TAG   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_TAG = 1'b1;
    localparam logic [15:0] PCM_TAG_RST   = 16'd1;
    localparam logic [15:0] FLOAT_TAG_RST = 16'd3;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_FMT,
        PH_SKIP,
        PH_HDR,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK     = 4'd0,
        ST_SHORT  = 4'd1,
        ST_RIFF   = 4'd2,
        ST_SIZE   = 4'd3,
        ST_WAVE   = 4'd4,
        ST_FMT    = 4'd5,
        ST_TAG    = 4'd6,
        ST_NODATA = 4'd7,
        ST_TRUNC  = 4'd8
    } t_status;

    localparam logic [1:0] SF_UINT8   = 2'd0;
    localparam logic [1:0] SF_INT16   = 2'd1;
    localparam logic [1:0] SF_INT32   = 2'd2;
    localparam logic [1:0] SF_FLOAT32 = 2'd3;

    // four-character tags, first character in the top byte
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [32:0] MIN_LEN      = 33'd44;
    localparam logic [32:0] RIFF_HDR_LEN = 33'd8;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        tag_byte = tag[{~idx, 3'b000} +: 8];
    endfunction

endpackage

@@ hdl/wsp_cfg_regs.sv @@
// wsp_cfg_regs: format tag configuration registers for the header parser.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_cfg_regs
    import wsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pcm_tag   <= PCM_TAG_RST;
            r_cfg.float_tag <= FLOAT_TAG_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PCM_TAG:   r_cfg.pcm_tag   <= i_cfg_data;
                CFG_FLOAT_TAG: r_cfg.float_tag <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/wsp_parse_core.sv @@
// wsp_parse_core: RIFF/WAVE walker state and per-word parse logic.
// Produces at most one result word per accepted byte. Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_parse_core
    import wsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output logic      o_res_valid,
    output t_out_word o_res
);

    logic [31:0] r_pos,        n_pos;
    logic [2:0]  r_field_shift, n_field_shift;
    logic [31:0] r_riff_size,  n_riff_size;
    logic [23:0] r_fmt_size,   n_fmt_size;
    logic [15:0] r_format_tag, n_format_tag;
    logic [15:0] r_channels,   n_channels;
    logic [31:0] r_rate,       n_rate;
    logic [15:0] r_bits,       n_bits;
    logic [31:0] r_cr,         n_cr;
    t_phase      r_phase,      n_phase;
    t_status     r_first_error, n_first_error;
    logic        r_data_found, n_data_found;
    logic [31:0] r_data_length, n_data_length;
    logic        r_id_match,   n_id_match;

    logic [7:0]  b;
    logic [2:0]  idx;
    t_status     err;
    logic [31:0] full_size;
    logic [31:0] cr_dec;
    logic        payload;
    logic [32:0] len;
    t_status     st;

    assign b   = i_word.in_byte;
    assign idx = r_field_shift;

    // next state
    always_comb begin
        n_pos         = (r_pos != '1) ? r_pos + 32'd1 : r_pos;
        n_field_shift = r_field_shift;
        n_riff_size   = r_riff_size;
        n_fmt_size    = r_fmt_size;
        n_format_tag  = r_format_tag;
        n_channels    = r_channels;
        n_rate        = r_rate;
        n_bits        = r_bits;
        n_cr          = r_cr;
        n_phase       = r_phase;
        n_data_found  = r_data_found;
        n_data_length = r_data_length;
        n_id_match    = r_id_match;
        err           = ST_OK;
        full_size     = {b, r_fmt_size};
        cr_dec        = r_cr - 32'd1;

        // fixed offsets of the file header and fmt chunk body
        if (r_pos < 32'd4) begin
            if (b != tag_byte(TAG_RIFF, r_pos[1:0])) err = ST_RIFF;
        end else if (r_pos < 32'd8) begin
            n_riff_size[{r_pos[1:0], 3'b000} +: 8] = b;
        end else if (r_pos < 32'd12) begin
            if (b != tag_byte(TAG_WAVE, r_pos[1:0])) err = ST_WAVE;
        end else if (r_pos == 32'd20) begin
            n_format_tag[7:0] = b;
        end else if (r_pos == 32'd21) begin
            n_format_tag[15:8] = b;
            if ({b, r_format_tag[7:0]} != i_cfg.pcm_tag &&
                {b, r_format_tag[7:0]} != i_cfg.float_tag) err = ST_TAG;
        end else if (r_pos == 32'd22) begin
            n_channels[7:0] = b;
        end else if (r_pos == 32'd23) begin
            n_channels[15:8] = b;
        end else if (r_pos >= 32'd24 && r_pos < 32'd28) begin
            n_rate[{r_pos[1:0], 3'b000} +: 8] = b;
        end else if (r_pos == 32'd34) begin
            n_bits[7:0] = b;
        end else if (r_pos == 32'd35) begin
            n_bits[15:8] = b;
        end

        case (r_phase)
            PH_RIFF: begin
                if (r_pos == 32'd11) begin
                    n_phase       = PH_FMT;
                    n_field_shift = 3'd0;
                end
            end
            PH_FMT: begin
                if (!idx[2]) begin
                    if (b != tag_byte(TAG_FMT, idx[1:0])) err = ST_FMT;
                end else if (idx != 3'd7) begin
                    n_fmt_size[{idx[1:0], 3'b000} +: 8] = b;
                end
                if (idx == 3'd7) begin
                    if (full_size != 32'd0) begin
                        n_phase = PH_SKIP;
                        n_cr    = full_size;
                    end else begin
                        n_phase       = PH_HDR;
                        n_field_shift = 3'd0;
                        n_id_match    = 1'b1;
                        n_cr          = 32'd0;
                    end
                end else begin
                    n_field_shift = idx + 3'd1;
                end
            end
            PH_SKIP: begin
                n_cr = cr_dec;
                if (cr_dec == 32'd0) begin
                    n_phase       = PH_HDR;
                    n_field_shift = 3'd0;
                    n_id_match    = 1'b1;
                end
            end
            PH_HDR: begin
                if (!idx[2]) begin
                    if (b != tag_byte(TAG_DATA, idx[1:0])) n_id_match = 1'b0;
                end else if (idx != 3'd7) begin
                    n_cr[{idx[1:0], 3'b000} +: 8] = b;
                end
                if (idx == 3'd7) begin
                    n_cr = {b, r_cr[23:0]};
                    if (r_id_match) begin
                        n_data_found  = 1'b1;
                        n_data_length = {b, r_cr[23:0]};
                        n_phase       = ({b, r_cr[23:0]} != 32'd0) ? PH_DATA : PH_DONE;
                    end else if ({b, r_cr[23:0]} != 32'd0) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_field_shift = 3'd0;
                        n_id_match    = 1'b1;
                        n_cr          = 32'd0;
                    end
                end else begin
                    n_field_shift = idx + 3'd1;
                end
            end
            PH_DATA: begin
                n_cr = cr_dec;
                if (cr_dec == 32'd0) n_phase = PH_DONE;
            end
            default: ;
        endcase

        n_first_error = (r_first_error == ST_OK) ? err : r_first_error;
    end

    // result word
    always_comb begin
        payload     = (r_phase == PH_DATA);
        o_res_valid = payload || i_word.last;
        o_res       = '0;
        len         = {1'b0, r_pos} + 33'd1;
        st          = ST_OK;
        if (payload) begin
            o_res.out_byte   = b;
            o_res.byte_valid = 1'b1;
        end
        if (i_word.last) begin
            if (len < MIN_LEN)                                   st = ST_SHORT;
            else if (n_first_error == ST_RIFF)                   st = ST_RIFF;
            else if (len != {1'b0, n_riff_size} + RIFF_HDR_LEN)  st = ST_SIZE;
            else if (n_first_error != ST_OK)                     st = n_first_error;
            else if (!n_data_found)                              st = ST_NODATA;
            else if (n_phase == PH_DATA)                         st = ST_TRUNC;
            else                                                 st = ST_OK;
            o_res.done_res      = 1'b1;
            o_res.status        = st;
            o_res.sample_format = SF_FLOAT32;
            if (n_format_tag == i_cfg.pcm_tag) begin
                if (n_bits == 16'd8)       o_res.sample_format = SF_UINT8;
                else if (n_bits == 16'd16) o_res.sample_format = SF_INT16;
                else if (n_bits == 16'd32) o_res.sample_format = SF_INT32;
            end
            o_res.channel_count = n_channels;
            o_res.sample_rate   = n_rate;
            o_res.data_size     = n_data_found ? n_data_length : 32'd0;
        end
    end

    // the last byte of a file returns the walker to its reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word.last)) begin
            r_pos         <= '0;
            r_field_shift <= '0;
            r_riff_size   <= '0;
            r_fmt_size    <= '0;
            r_format_tag  <= '0;
            r_channels    <= '0;
            r_rate        <= '0;
            r_bits        <= '0;
            r_cr          <= '0;
            r_phase       <= PH_RIFF;
            r_first_error <= ST_OK;
            r_data_found  <= 1'b0;
            r_data_length <= '0;
            r_id_match    <= 1'b1;
        end else if (i_accept) begin
            r_pos         <= n_pos;
            r_field_shift <= n_field_shift;
            r_riff_size   <= n_riff_size;
            r_fmt_size    <= n_fmt_size;
            r_format_tag  <= n_format_tag;
            r_channels    <= n_channels;
            r_rate        <= n_rate;
            r_bits        <= n_bits;
            r_cr          <= n_cr;
            r_phase       <= n_phase;
            r_first_error <= n_first_error;
            r_data_found  <= n_data_found;
            r_data_length <= n_data_length;
            r_id_match    <= n_id_match;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_word.last) |=> (r_pos == 32'd0 && r_phase == PH_RIFF))
        else $error("walker not cleared after last word");

    a_riff_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RIFF) |-> (r_field_shift == 3'd0))
        else $error("field shift moved during file header");

    a_found_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_found |-> (r_phase == PH_DATA || r_phase == PH_DONE))
        else $error("data chunk flagged outside data phases");

    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_SKIP) |-> (r_cr != 32'd0))
        else $error("zero byte count in counting phase");

endmodule

@@ hdl/wsp_out_stage.sv @@
// wsp_out_stage: result register between the parse core and the output channel.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_out_stage
    import wsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_data,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_push) begin
            r_data <= i_data;
        end
    end

endmodule

@@ hdl/wav_stream_header_parser.sv @@
// Each accepted byte's result word is registered in the output register.
// Throughput: one byte per cycle; input stalls only while a result word waits unread.
// Bytes that cause no result are consumed without an output word.
// Reset: synchronous active low; walker cleared at once, tags return to 1 and 3.
// Walker also clears itself after each byte flagged last. Needs wsp_pkg and submodules.
`timescale 1ns / 1ps

module wav_stream_header_parser
    import wsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg      cfg;
    logic      accept;
    logic      res_valid;
    t_out_word res;
    logic      space;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    wsp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wsp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (i_in_data),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
